@@ rtl/hrs_pkg.sv @@
// Shared types and constants for the hop round-trip statistics block.
package hrs_pkg;

    localparam int RTT_W  = 24;
    localparam int RFC_W  = 28;
    localparam int CNT_W  = 32;
    localparam int ADDR_W = 32;
    localparam int SEQ_W  = 16;
    localparam int HOP_W  = 8;
    localparam int SLOT_W = 4;

    localparam logic [0:0] REQ_SEND  = 1'b0;
    localparam logic [0:0] REQ_REPLY = 1'b1;

    typedef struct packed {
        logic load;       // capture input beat
        logic rd_hop;     // read hop stores at the send hop
        logic rd_seq;     // read sequence stores
        logic rd_reply;   // read hop stores at the matched hop
        logic path_step;  // read next path slot
        logic path_eval;  // compare path slot data
        logic calc;       // compute pre-divide values
        logic div_start;  // launch divider
        logic commit_send;
        logic commit_reply;
        logic emit_send;
        logic emit_reply;
        logic emit_zero;
    } t_cmd;

    typedef struct packed {
        logic is_reply;
        logic hop_ok;
        logic seq_ok;
        logic path_done;
        logic div_done;
        logic clearing;
    } t_sts;

endpackage

@@ rtl/hrs_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
module hrs_div import hrs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CNT_W-1:0] i_num,
    input  logic [CNT_W-1:0] i_den,
    output logic             o_busy,
    output logic [CNT_W-1:0] o_quo,
    output logic [CNT_W-1:0] o_rem
);
    localparam int CW = $clog2(CNT_W + 1);

    logic [CNT_W-1:0] r_q, r_d;
    logic [CNT_W:0]   r_r;
    logic [CW-1:0]    r_cnt;
    logic [CNT_W:0]   n_trial;
    logic [CNT_W:0]   n_sh;

    assign n_sh    = {r_r[CNT_W-1:0], r_q[CNT_W-1]};
    assign n_trial = n_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(CNT_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_d <= i_den;
            r_r <= '0;
        end else if (r_cnt != '0) begin
            if (!n_trial[CNT_W]) begin
                r_r <= n_trial;
                r_q <= {r_q[CNT_W-2:0], 1'b1};
            end else begin
                r_r <= n_sh;
                r_q <= {r_q[CNT_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_q;
    assign o_rem  = r_r[CNT_W-1:0];
endmodule

@@ rtl/hrs_ctrl.sv @@
// Sequencing state machine for the hop round-trip statistics block.
module hrs_ctrl import hrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SEMIT = 4'd3;
    localparam logic [3:0] S_QRD   = 4'd4;
    localparam logic [3:0] S_QCHK  = 4'd5;
    localparam logic [3:0] S_HRD   = 4'd6;
    localparam logic [3:0] S_PRD   = 4'd7;
    localparam logic [3:0] S_PCHK  = 4'd8;
    localparam logic [3:0] S_CALC  = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_DWAIT = 4'd11;
    localparam logic [3:0] S_COMM  = 4'd12;
    localparam logic [3:0] S_REMIT = 4'd13;
    localparam logic [3:0] S_ZEMIT = 4'd14;

    logic [3:0] r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st  = r_st;
        o_cmd = '0;
        case (r_st)
            S_IDLE: begin
                if (i_start && !i_sts.clearing) begin
                    o_cmd.load = 1'b1;
                    n_st = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.is_reply) begin
                    o_cmd.rd_seq = 1'b1;
                    n_st = S_QRD;
                end else if (i_sts.hop_ok) begin
                    o_cmd.rd_hop = 1'b1;
                    n_st = S_SRD;
                end else begin
                    n_st = S_ZEMIT;
                end
            end
            S_SRD: begin
                o_cmd.commit_send = 1'b1;
                n_st = S_SEMIT;
            end
            S_SEMIT: begin
                o_cmd.emit_send = 1'b1;
                n_st = S_IDLE;
            end
            S_QRD: n_st = S_QCHK;
            S_QCHK: begin
                if (i_sts.seq_ok) begin
                    o_cmd.rd_reply = 1'b1;
                    n_st = S_HRD;
                end else begin
                    n_st = S_ZEMIT;
                end
            end
            S_HRD: begin
                o_cmd.path_step = 1'b1;
                n_st = S_PRD;
            end
            S_PRD: n_st = S_PCHK;
            S_PCHK: begin
                o_cmd.path_eval = 1'b1;
                if (i_sts.path_done) begin
                    n_st = S_CALC;
                end else begin
                    n_st = S_HRD;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_st = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_st = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    n_st = S_COMM;
                end
            end
            S_COMM: begin
                o_cmd.commit_reply = 1'b1;
                n_st = S_REMIT;
            end
            S_REMIT: begin
                o_cmd.emit_reply = 1'b1;
                n_st = S_IDLE;
            end
            S_ZEMIT: begin
                o_cmd.emit_zero = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_busy = (r_st != S_IDLE) || i_sts.clearing;
endmodule

@@ rtl/hrs_dp.sv @@
// Datapath: sequence and hop stores, path search and statistics update.
module hrs_dp import hrs_pkg::*; #(
    parameter int MAX_HOPS      = 256,
    parameter int PATHS_PER_HOP = 8,
    parameter int SEQ_SPACE     = 65536,
    parameter int SEQ_FIRST     = 33000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_req_type,
    input  logic [HOP_W-1:0]   i_hop,
    input  logic [SEQ_W-1:0]   i_seq,
    input  logic [ADDR_W-1:0]  i_reply_addr,
    input  logic [RTT_W-1:0]   i_rtt_us,
    output logic               o_valid,
    output logic [SEQ_W-1:0]   o_seq_out,
    output logic [HOP_W-1:0]   o_hop_out,
    output logic               o_accepted,
    output logic [SLOT_W-1:0]  o_path_slot,
    output logic               o_new_path,
    output logic [RTT_W-1:0]   o_best_us,
    output logic [RTT_W-1:0]   o_worst_us,
    output logic [RTT_W-1:0]   o_avg_us,
    output logic [RTT_W-1:0]   o_jitter_us,
    output logic [RTT_W-1:0]   o_jitter_avg_us,
    output logic [RTT_W-1:0]   o_jitter_max_us,
    output logic [RFC_W-1:0]   o_jitter_rfc_est
);
    localparam int HW  = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
    localparam int QW  = $clog2(SEQ_SPACE);
    localparam int PW  = (PATHS_PER_HOP > 1) ? $clog2(PATHS_PER_HOP) : 1;
    localparam int PCW = $clog2(PATHS_PER_HOP + 1);
    localparam int FIRST = (SEQ_FIRST < SEQ_SPACE) ? SEQ_FIRST : 0;
    localparam int SW  = (SEQ_SPACE * 2 > 65536) ? 17 : QW + 1;
    localparam int PD  = MAX_HOPS * PATHS_PER_HOP;
    localparam int CLR_N = (SEQ_SPACE > PD) ? SEQ_SPACE : PD;
    localparam int CLW = $clog2(CLR_N) + 1;
    localparam logic [CNT_W-1:0] CMAX = '1;
    localparam logic [RFC_W-1:0] M28  = '1;

    // per-hop record: valid bits stand for the all-zero reset
    typedef struct packed {
        logic [CNT_W-1:0] xmit;
        logic [CNT_W-1:0] ret;
        logic [RTT_W-1:0] last;
        logic [RTT_W-1:0] best;
        logic [RTT_W-1:0] worst;
        logic [RTT_W-1:0] avg;
        logic [63:0]      sumsq;
        logic [RTT_W-1:0] jcur;
        logic [RTT_W-1:0] javg;
        logic [RTT_W-1:0] jmax;
        logic [RFC_W-1:0] rfc;
        logic [ADDR_W-1:0] prim;
        logic [2:0]       flags;
    } t_hrec;

    t_hrec            m_hop [MAX_HOPS];
    logic [HOP_W-1:0] m_seqhop [SEQ_SPACE];
    logic             m_transit [SEQ_SPACE];
    logic [ADDR_W-1:0] m_path [MAX_HOPS*PATHS_PER_HOP];

    logic [MAX_HOPS-1:0]               r_hvalid;
    logic [CLW-1:0] r_clr;
    logic         r_clearing;

    logic [SEQ_W-1:0] r_next_seq;
    logic             r_req;
    logic [HOP_W-1:0] r_hop;
    logic [SEQ_W-1:0] r_seq;
    logic [ADDR_W-1:0] r_addr;
    logic [RTT_W-1:0] r_rtt;

    t_hrec            r_rd, r_rec, r_wrec;
    logic             r_rd_v;
    logic [HOP_W-1:0] r_qhop;
    logic             r_qtr;
    logic [HW-1:0]    r_h;
    logic [PCW-1:0]   r_pi;
    logic [ADDR_W-1:0] r_pdat;
    logic             r_pdone;
    logic [SLOT_W-1:0] r_slot;
    logic             r_fresh;
    logic             r_pwr;
    logic [PW-1:0]    r_pwidx;

    logic [CNT_W-1:0] r_n;
    logic             r_dneg, r_jneg;
    logic [CNT_W-1:0] r_dabs, r_jabs;
    logic [1:0]       r_dphase;
    logic [CNT_W-1:0] r_dq_avg;
    logic             r_drem_nz;
    logic [CNT_W-1:0] r_dq_j;

    logic             div_start, div_busy;
    logic [CNT_W-1:0] div_num, div_quo, div_rem;

    hrs_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(r_n), .o_busy(div_busy),
        .o_quo(div_quo), .o_rem(div_rem)
    );

    // memory clearing pass over the transit bits and path store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clearing <= 1'b1;
        end else if (r_clearing) begin
            if (r_clr == CLW'(CLR_N - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_hop  <= i_hop;
            r_seq  <= i_seq;
            r_addr <= i_reply_addr;
            r_rtt  <= i_rtt_us;
        end
    end

    logic [HW-1:0] hop_idx;
    logic [HW-1:0] rd_idx;
    assign hop_idx = HW'(r_hop);
    assign rd_idx  = i_cmd.rd_hop ? hop_idx : HW'(r_qhop);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_hop || i_cmd.rd_reply) begin
            r_rd <= m_hop[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_hop || i_cmd.rd_reply) begin
            r_rd_v <= r_hvalid[rd_idx];
            r_h    <= rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_seq) begin
            r_qhop <= m_seqhop[r_seq[QW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_seq) begin
            r_qtr <= m_transit[r_seq[QW-1:0]];
        end
    end

    logic [PW-1:0] pidx;
    logic [HW+PW-1:0] paddr;
    assign pidx  = PW'(r_pi);
    assign paddr = (HW+PW)'(r_h) * (HW+PW)'(PATHS_PER_HOP) + (HW+PW)'(pidx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.path_step) begin
            r_pdat <= m_path[paddr];
        end
    end

    t_hrec cur;
    always_comb begin
        cur = r_rd_v ? r_rd : '0;
    end

    logic [ADDR_W-1:0] pval;
    assign pval = r_pdat;

    // path search
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_reply) begin
            r_pi    <= '0;
            r_pdone <= 1'b0;
            r_pwr   <= 1'b0;
            r_fresh <= 1'b0;
            r_slot  <= '0;
        end else if (i_cmd.path_step && !i_cmd.path_eval) begin
            if (cur.prim == '0) begin
                r_pdone <= 1'b1;
                r_pwr   <= 1'b1;
                r_pwidx <= '0;
                r_slot  <= '0;
                r_fresh <= (r_addr != '0);
            end
        end else if (i_cmd.path_eval && !r_pdone) begin
            if (pval == r_addr || pval == '0) begin
                r_pdone <= 1'b1;
                r_slot  <= SLOT_W'(r_pi);
                if (pval != r_addr) begin
                    r_pwr   <= 1'b1;
                    r_pwidx <= pidx;
                    r_fresh <= 1'b1;
                end
            end else if (r_pi == PCW'(PATHS_PER_HOP - 1)) begin
                r_pdone <= 1'b1;
                r_slot  <= (PATHS_PER_HOP > 15) ? 4'd15 : SLOT_W'(PATHS_PER_HOP);
            end else begin
                r_pi <= r_pi + 1'b1;
            end
        end
    end

    logic path_hit;
    assign path_hit = (pval == r_addr || pval == '0 ||
                       r_pi == PCW'(PATHS_PER_HOP - 1));

    // statistics before the divide
    logic [RTT_W-1:0] jc;
    logic             first;
    logic [CNT_W-1:0] nn;
    assign first = (cur.ret == '0);
    assign jc    = first ? '0 :
                   ((r_rtt >= cur.last) ? r_rtt - cur.last : cur.last - r_rtt);
    assign nn    = (cur.ret == CMAX) ? CMAX : cur.ret + 1'b1;

    logic [RTT_W-1:0] oavg, ojavg;
    assign oavg  = first ? '0 : cur.avg;
    assign ojavg = cur.javg;

    t_hrec crec;
    always_comb begin
        crec      = cur;
        crec.jcur = jc;
        crec.ret  = nn;
        crec.avg  = oavg;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_rec      <= crec;
            r_n        <= nn;
            r_dneg     <= (r_rtt < oavg);
            r_dabs     <= CNT_W'((r_rtt < oavg) ? oavg - r_rtt : r_rtt - oavg);
            r_jneg     <= (jc < ojavg);
            r_jabs     <= CNT_W'((jc < ojavg) ? ojavg - jc : jc - ojavg);
        end
    end

    // two divides back to back on the shared unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dphase <= '0;
        end else if (i_cmd.div_start) begin
            r_dphase <= 2'd1;
        end else if (r_dphase == 2'd1 && !div_busy) begin
            r_dphase <= 2'd2;
        end else if (r_dphase == 2'd2 && !div_busy) begin
            r_dphase <= 2'd3;
        end else if (r_dphase == 2'd3 && !div_busy && !div_start) begin
            r_dphase <= 2'd0;
        end
    end

    logic [1:0] r_dlaunch;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dlaunch <= '0;
        end else begin
            r_dlaunch <= {r_dlaunch[0], i_cmd.div_start};
        end
    end

    assign div_start = i_cmd.div_start || (r_dphase == 2'd2 && !div_busy);
    assign div_num   = i_cmd.div_start ? r_dabs : r_jabs;

    always_ff @(posedge i_clk) begin
        if (r_dphase == 2'd2 && !div_busy) begin
            r_dq_avg  <= div_quo;
            r_drem_nz <= (div_rem != '0);
        end
        if (r_dphase == 2'd3 && !div_busy) begin
            r_dq_j <= div_quo;
        end
    end

    assign o_sts.div_done = (r_dphase == 2'd0) && (r_dlaunch == 2'b00) &&
                            !div_busy;

    // final values
    logic [CNT_W-1:0] astep;
    logic [RTT_W-1:0] navg, njavg, nbest, nworst, njmax;
    logic [RFC_W-1:0] nrfc;
    logic [28:0]      rsum;
    logic signed [RTT_W+1:0] dsg, esg;
    logic signed [2*RTT_W+3:0] psg;
    logic [63:0]      prod;
    logic [RTT_W+1:0] avgs;

    always_comb begin
        astep = r_dq_avg + CNT_W'(r_drem_nz);
        if (r_dneg) begin
            avgs = (RTT_W+2)'(r_rec.avg) - (RTT_W+2)'(astep);
        end else begin
            avgs = (RTT_W+2)'(r_rec.avg) + (RTT_W+2)'(r_dq_avg);
        end
        navg  = avgs[RTT_W+1] ? '0 : RTT_W'(avgs);
        njavg = r_jneg ? RTT_W'(r_rec.javg - RTT_W'(r_dq_j))
                       : RTT_W'(r_rec.javg + RTT_W'(r_dq_j));
        nbest  = (r_n == 1) ? r_rtt : ((r_rtt < r_rec.best) ? r_rtt : r_rec.best);
        nworst = (r_n == 1) ? r_rtt : ((r_rtt > r_rec.worst) ? r_rtt : r_rec.worst);
        njmax  = (r_n == 1) ? '0 :
                 ((r_rec.jcur > r_rec.jmax) ? r_rec.jcur : r_rec.jmax);
        rsum = 29'(((r_n == 1) ? '0 : r_rec.rfc)) + 29'(r_rec.jcur)
             - 29'((29'(((r_n == 1) ? '0 : r_rec.rfc)) + 29'd8) >> 4);
        nrfc = rsum[28] ? M28 : rsum[RFC_W-1:0];
        dsg  = $signed({2'b00, r_rtt}) - $signed({2'b00, r_rec.avg});
        esg  = $signed({2'b00, r_rtt}) - $signed({2'b00, navg});
        psg  = dsg * esg;
        prod = 64'(psg);
    end

    logic [63:0] r_prod;
    always_ff @(posedge i_clk) begin
        r_prod <= prod;
    end

    t_hrec wrec;
    always_comb begin
        wrec        = r_rec;
        wrec.last   = r_rtt;
        wrec.best   = nbest;
        wrec.worst  = nworst;
        wrec.avg    = navg;
        wrec.sumsq  = ((r_n == 1) ? 64'd0 : r_rec.sumsq) + r_prod;
        wrec.javg   = njavg;
        wrec.jmax   = njmax;
        wrec.rfc    = nrfc;
        wrec.flags  = (r_rec.flags & 3'b100) | 3'b100;
        if (r_rec.prim == '0) begin
            wrec.prim = r_addr;
        end
    end

    t_hrec srec;
    always_comb begin
        srec       = cur;
        srec.xmit  = (cur.xmit == CMAX) ? cur.xmit : cur.xmit + 1'b1;
        srec.flags = cur.flags | 3'b011;
        if (cur.flags[1]) begin
            srec.flags[2] = 1'b0;
        end
    end

    // hop record writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_send) begin
            m_hop[r_h] <= srec;
        end else if (i_cmd.commit_reply) begin
            m_hop[r_h] <= wrec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_reply) begin
            r_wrec <= wrec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= '0;
        end else if (i_cmd.commit_send || i_cmd.commit_reply) begin
            r_hvalid[r_h] <= 1'b1;
        end
    end

    logic [HW+PW-1:0] pwaddr;
    assign pwaddr = (HW+PW)'(r_h) * (HW+PW)'(PATHS_PER_HOP) + (HW+PW)'(r_pwidx);

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            if (r_clr < CLW'(PD)) begin
                m_path[(HW+PW)'(r_clr)] <= '0;
            end
        end else if (i_cmd.commit_reply && r_pwr) begin
            m_path[pwaddr] <= r_addr;
        end
    end

    // sequence stores
    logic [SW-1:0] nxs;
    assign nxs = SW'(r_next_seq) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_seq <= SEQ_W'(FIRST);
        end else if (i_cmd.commit_send) begin
            r_next_seq <= (nxs >= SW'(SEQ_SPACE)) ? SEQ_W'(FIRST) : SEQ_W'(nxs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_send) begin
            m_seqhop[r_next_seq[QW-1:0]] <= r_hop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            m_transit[r_clr[QW-1:0]] <= 1'b0;
        end else if (i_cmd.commit_send) begin
            m_transit[r_next_seq[QW-1:0]] <= 1'b1;
        end else if (i_cmd.commit_reply) begin
            m_transit[r_seq[QW-1:0]] <= 1'b0;
        end
    end

    logic [SEQ_W-1:0] r_sent_seq;
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_send) begin
            r_sent_seq <= r_next_seq;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit_send || i_cmd.emit_reply || i_cmd.emit_zero;
        end
    end

    t_hrec orec;
    assign orec = i_cmd.emit_send ? srec : r_wrec;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_zero) begin
            o_seq_out        <= r_req ? r_seq : '0;
            o_hop_out        <= r_req ? '0 : r_hop;
            o_accepted       <= 1'b0;
            o_path_slot      <= '0;
            o_new_path       <= 1'b0;
            o_best_us        <= '0;
            o_worst_us       <= '0;
            o_avg_us         <= '0;
            o_jitter_us      <= '0;
            o_jitter_avg_us  <= '0;
            o_jitter_max_us  <= '0;
            o_jitter_rfc_est <= '0;
        end else if (i_cmd.emit_send || i_cmd.emit_reply) begin
            o_seq_out        <= i_cmd.emit_send ? r_sent_seq : r_seq;
            o_hop_out        <= i_cmd.emit_send ? r_hop : HOP_W'(r_h);
            o_accepted       <= i_cmd.emit_reply;
            o_path_slot      <= i_cmd.emit_reply ? r_slot : '0;
            o_new_path       <= i_cmd.emit_reply && r_fresh;
            o_best_us        <= orec.best;
            o_worst_us       <= orec.worst;
            o_avg_us         <= orec.avg;
            o_jitter_us      <= orec.jcur;
            o_jitter_avg_us  <= orec.javg;
            o_jitter_max_us  <= orec.jmax;
            o_jitter_rfc_est <= orec.rfc;
        end
    end

    assign o_sts.is_reply  = (r_req == REQ_REPLY);
    assign o_sts.hop_ok    = (32'(r_hop) < 32'(MAX_HOPS));
    assign o_sts.seq_ok    = (32'(r_seq) < 32'(SEQ_SPACE)) && r_qtr;
    assign o_sts.path_done = r_pdone || (cur.prim == '0) || path_hit;
    assign o_sts.clearing  = r_clearing;
endmodule

@@ rtl/hop_rtt_statistics_top.sv @@
// Top level of the hop round-trip statistics block.
// A probe reads and updates its hop record; a reply also searches the path slots one at a
// time and runs two passes of the serial divider.
// One item at a time: busy drops in the cycle the result strobe is driven.
// Reset is synchronous; a clearing pass over the in-transit bits and the path store follows,
// and busy holds high through it. The receiver cannot stall.
module hop_rtt_statistics_top import hrs_pkg::*; #(
    parameter int MAX_HOPS      = 256,
    parameter int PATHS_PER_HOP = 8,
    parameter int SEQ_SPACE     = 65536,
    parameter int SEQ_FIRST     = 33000
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [HOP_W-1:0]  i_hop,
    input  logic [SEQ_W-1:0]  i_seq,
    input  logic [ADDR_W-1:0] i_reply_addr,
    input  logic [RTT_W-1:0]  i_rtt_us,
    output logic              o_valid,
    output logic [SEQ_W-1:0]  o_seq_out,
    output logic [HOP_W-1:0]  o_hop_out,
    output logic              o_accepted,
    output logic [SLOT_W-1:0] o_path_slot,
    output logic              o_new_path,
    output logic [RTT_W-1:0]  o_best_us,
    output logic [RTT_W-1:0]  o_worst_us,
    output logic [RTT_W-1:0]  o_avg_us,
    output logic [RTT_W-1:0]  o_jitter_us,
    output logic [RTT_W-1:0]  o_jitter_avg_us,
    output logic [RTT_W-1:0]  o_jitter_max_us,
    output logic [RFC_W-1:0]  o_jitter_rfc_est
);
    t_cmd cmd;
    t_sts sts;

    hrs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy)
    );

    hrs_dp #(
        .MAX_HOPS(MAX_HOPS), .PATHS_PER_HOP(PATHS_PER_HOP),
        .SEQ_SPACE(SEQ_SPACE), .SEQ_FIRST(SEQ_FIRST)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_req_type(i_req_type), .i_hop(i_hop), .i_seq(i_seq),
        .i_reply_addr(i_reply_addr), .i_rtt_us(i_rtt_us),
        .o_valid(o_valid), .o_seq_out(o_seq_out), .o_hop_out(o_hop_out),
        .o_accepted(o_accepted), .o_path_slot(o_path_slot),
        .o_new_path(o_new_path), .o_best_us(o_best_us),
        .o_worst_us(o_worst_us), .o_avg_us(o_avg_us),
        .o_jitter_us(o_jitter_us), .o_jitter_avg_us(o_jitter_avg_us),
        .o_jitter_max_us(o_jitter_max_us), .o_jitter_rfc_est(o_jitter_rfc_est)
    );

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("strobe without work");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("beat not taken");
    a_accept_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> (o_path_slot == '0 && !o_new_path))
        else $error("unmatched beat carries path data");
endmodule
